/* sv/tsp_pkg.sv */
// Package for the typed slot pool: tag and status codes, field widths and
// the default pool size. Depends on nothing.
package tsp_pkg;

	localparam int SLOT_COUNT_DEF = 8;
	localparam int CNT_W = 7;
	localparam int IDX_OUT_W = 6;
	localparam int VAL_W = 32;

	typedef enum logic [1:0] {
		TAG_FREE = 2'd0,
		TAG_ONE  = 2'd1,
		TAG_TWO  = 2'd2
	} tag_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_POOL_FULL = 2'd1,
		ST_NO_ITEM   = 2'd2
	} status_t;

	localparam logic FUNC_PRODUCE = 1'b0;
	localparam logic FUNC_CONSUME = 1'b1;

endpackage

/* sv/typed_slot_pool.sv */
// Typed slot pool: slot tags and counts in flip-flops, slot values in tsp_ram.
// Depends on tsp_pkg and tsp_ram.
//
// Usage: a request is taken at a rising edge with start high and busy low.
// func selects produce or consume, item_type selects type 1 or type 2, and
// value_in is the value stored on a produce. A produce fills the lowest free
// slot; a consume empties the lowest slot of the requested type.
// Each item gives one result, shown for exactly one cycle with strobe high,
// in the cycle after the item is taken: status, slot_index and value_out.
// The result is registered; value_out comes from the registered read of the value memory.
// Throughput is one item per cycle; the slot search is a priority encoder
// over the tag flip-flops and is done in the cycle the item is taken.
// A rejected request (pool full, or no item of that type) changes nothing
// and reports slot index 0 and value 0.
// Reset clears all tags to free, sets the free count to the pool size and
// holds busy high until the first clock after reset is released.
// The receiver cannot stall; results must be taken as they appear.
module typed_slot_pool #(
	parameter int SLOT_COUNT = tsp_pkg::SLOT_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             func,
	input  logic                             item_type,
	input  logic signed [tsp_pkg::VAL_W-1:0] value_in,
	output logic                             strobe,
	output logic [1:0]                       status,
	output logic [tsp_pkg::IDX_OUT_W-1:0]    slot_index,
	output logic signed [tsp_pkg::VAL_W-1:0] value_out
);

	import tsp_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	tag_t             tag_q [SLOT_COUNT];
	logic [CNT_W-1:0] free_q;
	logic [CNT_W-1:0] one_q;
	logic [CNT_W-1:0] two_q;
	logic             busy_q;

	logic             accept;
	logic             consume;
	tag_t             want_tag;
	tag_t             new_tag;
	logic [IDX_W-1:0] found_slot;
	logic             type_empty;
	logic             ok;

	logic             strobe_s1;
	status_t          status_s1;
	logic [IDX_W-1:0] slot_s1;
	logic             take_s1;
	logic [VAL_W-1:0] ram_rdata;

	assign accept = start && !busy_q;
	assign consume = (func == FUNC_CONSUME);
	assign new_tag = item_type ? TAG_TWO : TAG_ONE;
	assign want_tag = consume ? new_tag : TAG_FREE;
	assign type_empty = item_type ? (two_q == '0) : (one_q == '0);
	assign ok = consume ? !type_empty : (free_q != '0);

	always_comb begin
		found_slot = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (tag_q[i] == want_tag) begin
				found_slot = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				tag_q[i] <= TAG_FREE;
			end
			free_q <= CNT_W'(SLOT_COUNT);
			one_q <= '0;
			two_q <= '0;
			busy_q <= 1'b1;
			strobe_s1 <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			strobe_s1 <= accept;
			if (accept && ok) begin
				if (consume) begin
					tag_q[found_slot] <= TAG_FREE;
					free_q <= free_q + CNT_W'(1);
					if (item_type) begin
						two_q <= two_q - CNT_W'(1);
					end else begin
						one_q <= one_q - CNT_W'(1);
					end
				end else begin
					tag_q[found_slot] <= new_tag;
					free_q <= free_q - CNT_W'(1);
					if (item_type) begin
						two_q <= two_q + CNT_W'(1);
					end else begin
						one_q <= one_q + CNT_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			take_s1 <= consume && ok;
			slot_s1 <= ok ? found_slot : '0;
			if (ok) begin
				status_s1 <= ST_DONE;
			end else if (consume) begin
				status_s1 <= ST_NO_ITEM;
			end else begin
				status_s1 <= ST_POOL_FULL;
			end
		end
	end

	tsp_ram #(
		.WIDTH(VAL_W),
		.DEPTH(SLOT_COUNT)
	) u_value_ram (
		.clk   (clk),
		.we    (accept && ok && !consume),
		.waddr (found_slot),
		.wdata (value_in),
		.re    (accept && ok && consume),
		.raddr (found_slot),
		.rdata (ram_rdata)
	);

	assign busy = busy_q;
	assign strobe = strobe_s1;
	assign status = status_s1;
	assign slot_index = IDX_OUT_W'(slot_s1);
	assign value_out = take_s1 ? signed'(ram_rdata) : '0;

endmodule

/* sv/tsp_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module tsp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/typed_slot_pool_chk.sv */
// Port-level checker for the typed slot pool, bound to the top level.
// Depends on tsp_pkg and typed_slot_pool.
module typed_slot_pool_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             func,
	input logic                             strobe,
	input logic [1:0]                       status,
	input logic [tsp_pkg::IDX_OUT_W-1:0]    slot_index,
	input logic signed [tsp_pkg::VAL_W-1:0] value_out
);

	import tsp_pkg::*;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> strobe)
		else $error("accepted item gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start && !busy))
		else $error("result without an accepted item");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status != ST_DONE) |-> (slot_index == '0 && value_out == '0))
		else $error("rejected item reports nonzero slot or value");

	a_full_is_produce: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status == ST_POOL_FULL) |-> ($past(func) == FUNC_PRODUCE))
		else $error("pool full reported for a consume");

	a_none_is_consume: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && status == ST_NO_ITEM) |-> ($past(func) == FUNC_CONSUME))
		else $error("no item reported for a produce");

endmodule

bind typed_slot_pool typed_slot_pool_chk u_chk (.*);
